>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/wita_pkg.sv
// ----------------------------------------------------------------------------
// wita_pkg
// Shared types, codes and sizing helpers for the worker ID table allocator.
// ----------------------------------------------------------------------------
package wita_pkg;

  localparam int SLOT_COUNT_DEF    = 64;
  localparam int DYNAMIC_BASE_DEF  = 32;
  localparam int DYNAMIC_COUNT_DEF = 32;

  localparam logic [15:0] NULL_WORKER_ID = 16'h0000;

  typedef enum logic [2:0] {
    REQ_STATIC   = 3'd0,
    REQ_DYNAMIC  = 3'd1,
    REQ_RELEASE  = 3'd2,
    REQ_DEPLOYED = 3'd3,
    REQ_TERM     = 3'd4,
    REQ_QUERY    = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_FREE = 3'd1,
    ST_RANGE   = 3'd2,
    ST_DYN     = 3'd3,
    ST_BUSY    = 3'd4,
    ST_WRONG   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SLOT_INACTIVE    = 2'd0,
    SLOT_DEPLOYING   = 2'd1,
    SLOT_ACTIVE      = 2'd2,
    SLOT_TERMINATING = 2'd3
  } slot_state_t;

  // slot table write port
  typedef struct packed {
    logic        en;
    slot_state_t state;
  } slot_wr_t;

  // free list control / status
  typedef struct packed {
    logic pop;
    logic push;
  } fl_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fl_stat_t;

  // width of a local ID as held in the free list
  function automatic int fid_width(input int slots, input int base, input int count);
    int top_val;
    top_val = slots - 1;
    if (base + count - 1 > top_val) top_val = base + count - 1;
    return $clog2(top_val + 1);
  endfunction

  function automatic int ptr_width(input int count);
    return (count > 1) ? $clog2(count) : 1;
  endfunction

endpackage

>>> rtl/wita_slot_table.sv
// ----------------------------------------------------------------------------
// wita_slot_table
// Per-slot state memory with reset-cleared valid bits, registered read and
// write-to-read forwarding.
// ----------------------------------------------------------------------------
module wita_slot_table
  import wita_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int SLOT_W     = $clog2(SLOT_COUNT)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] rd_addr,
  output slot_state_t       rd_state,
  input  slot_wr_t          wr,
  input  logic [SLOT_W-1:0] wr_addr
);

  slot_state_t             mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]   valid_r;
  slot_state_t             rd_state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.state;
    end
  end

  // a never-written slot reads inactive; a same-edge write wins
  always_ff @(posedge clk) begin
    if (wr.en && (wr_addr == rd_addr)) begin
      rd_state_r <= wr.state;
    end else if (valid_r[rd_addr]) begin
      rd_state_r <= mem[rd_addr];
    end else begin
      rd_state_r <= SLOT_INACTIVE;
    end
  end

  assign rd_state = rd_state_r;

endmodule

>>> rtl/wita_free_list.sv
// ----------------------------------------------------------------------------
// wita_free_list
// Circular FIFO of free dynamic IDs. The head is prefetched into a register
// each cycle; entries never written read as base plus index.
// ----------------------------------------------------------------------------
module wita_free_list
  import wita_pkg::*;
#(
  parameter int DYNAMIC_BASE  = DYNAMIC_BASE_DEF,
  parameter int DYNAMIC_COUNT = DYNAMIC_COUNT_DEF,
  parameter int FID_W         = fid_width(SLOT_COUNT_DEF, DYNAMIC_BASE_DEF, DYNAMIC_COUNT_DEF)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fl_ctrl_t         ctrl,
  input  logic [FID_W-1:0] push_id,
  output fl_stat_t         stat,
  output logic [FID_W-1:0] head_id
);

  localparam int PTR_W = ptr_width(DYNAMIC_COUNT);
  localparam int CNT_W = $clog2(DYNAMIC_COUNT + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DYNAMIC_COUNT - 1);

  logic [FID_W-1:0] mem [DYNAMIC_COUNT];

  logic [PTR_W-1:0] take_r, take_nxt;
  logic [PTR_W-1:0] ret_r, ret_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             wrapped_r, wrapped_nxt;
  logic [FID_W-1:0] rd_r;
  logic             written_r;

  always_comb begin
    take_nxt    = take_r;
    ret_nxt     = ret_r;
    count_nxt   = count_r;
    wrapped_nxt = wrapped_r;
    if (ctrl.pop) begin
      take_nxt  = (take_r == PTR_LAST) ? '0 : take_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
    if (ctrl.push) begin
      ret_nxt   = (ret_r == PTR_LAST) ? '0 : ret_r + 1'b1;
      count_nxt = count_r + 1'b1;
      if (ret_r == PTR_LAST) wrapped_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      take_r    <= '0;
      ret_r     <= '0;
      count_r   <= CNT_W'(DYNAMIC_COUNT);
      wrapped_r <= 1'b0;
      written_r <= 1'b0;
    end else begin
      take_r    <= take_nxt;
      ret_r     <= ret_nxt;
      count_r   <= count_nxt;
      wrapped_r <= wrapped_nxt;
      // entries below the return pointer have been written, all once it wraps
      written_r <= wrapped_nxt || (take_nxt < ret_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[ret_r] <= push_id;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && (ret_r == take_nxt)) begin
      rd_r <= push_id;
    end else begin
      rd_r <= mem[take_nxt];
    end
  end

  assign head_id    = written_r ? rd_r : FID_W'(DYNAMIC_BASE) + FID_W'(take_r);
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(DYNAMIC_COUNT));

endmodule

>>> rtl/worker_id_table_allocator.sv
// ----------------------------------------------------------------------------
// worker_id_table_allocator
// Worker slot state table with static reservation and a free-ID FIFO for
// dynamic reservation.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start high; busy is always low, so one
// request per cycle is sustained. Each request gives exactly one result word,
// shown on the out_ ports for one cycle with out_strobe high: the slot table
// read and free-ID head prefetch are registered along with the request, and
// the checks and state update sit between that register and the result
// register. Results cannot be held off. node_id is written over the APB port
// at byte address 0.
module worker_id_table_allocator
  import wita_pkg::*;
#(
  parameter int SLOT_COUNT    = SLOT_COUNT_DEF,
  parameter int DYNAMIC_BASE  = DYNAMIC_BASE_DEF,
  parameter int DYNAMIC_COUNT = DYNAMIC_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_worker_id,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [15:0] out_result_id,
  output logic [1:0]  out_slot_state,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "assert_macros.svh"

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int FID_W  = fid_width(SLOT_COUNT, DYNAMIC_BASE, DYNAMIC_COUNT);

  // config
  logic [7:0] node_id_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= 8'd0;
    end else if (cfg_wr && (paddr[2] == 1'b0)) begin
      node_id_r <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == 1'b0) ? {24'd0, node_id_r} : 32'd0;

  // stage 1
  logic        s1_valid_r;
  logic [2:0]  s1_req_r;
  logic [7:0]  s1_local_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_req_r   <= in_req_type;
      s1_local_r <= in_worker_id[7:0];
    end
  end

  slot_state_t       tbl_state;
  slot_wr_t          tbl_wr;
  logic [SLOT_W-1:0] tbl_wr_addr;
  fl_ctrl_t          fl_ctrl;
  fl_stat_t          fl_stat;
  logic [FID_W-1:0]  head_id;

  wita_slot_table #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_W     (SLOT_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (in_worker_id[SLOT_W-1:0]),
    .rd_state (tbl_state),
    .wr       (tbl_wr),
    .wr_addr  (tbl_wr_addr)
  );

  wita_free_list #(
    .DYNAMIC_BASE  (DYNAMIC_BASE),
    .DYNAMIC_COUNT (DYNAMIC_COUNT),
    .FID_W         (FID_W)
  ) u_free (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (fl_ctrl),
    .push_id (FID_W'(s1_local_r[SLOT_W-1:0])),
    .stat    (fl_stat),
    .head_id (head_id)
  );

  logic        local_in_range;
  logic        local_is_dyn;
  logic        head_in_range;
  status_t     res_status;
  logic [7:0]  res_local;
  slot_state_t res_state;

  assign local_in_range = ({1'b0, s1_local_r} < 9'(SLOT_COUNT));
  assign local_is_dyn   = ({1'b0, s1_local_r} >= 9'(DYNAMIC_BASE));
  assign head_in_range  = ((FID_W + 1)'(head_id) < (FID_W + 1)'(SLOT_COUNT));

  // IDs in the free list always belong to inactive slots, so the head slot
  // needs no state lookup on dynamic reserve.
  always_comb begin
    res_status   = ST_OK;
    res_local    = 8'd0;
    res_state    = SLOT_INACTIVE;
    tbl_wr.en    = 1'b0;
    tbl_wr.state = SLOT_INACTIVE;
    tbl_wr_addr  = s1_local_r[SLOT_W-1:0];
    fl_ctrl      = '0;
    if (s1_req_r == REQ_DYNAMIC) begin
      tbl_wr_addr = head_id[SLOT_W-1:0];
      priority if (fl_stat.empty) begin
        res_status = ST_NO_FREE;
      end else if (!head_in_range) begin
        res_status = ST_RANGE;
      end else begin
        fl_ctrl.pop  = 1'b1;
        tbl_wr.en    = 1'b1;
        tbl_wr.state = SLOT_DEPLOYING;
        res_local    = 8'(head_id);
        res_state    = SLOT_DEPLOYING;
      end
    end else if (s1_req_r > REQ_QUERY) begin
      res_status = ST_WRONG;
    end else if (!local_in_range) begin
      res_status = ST_RANGE;
    end else begin
      res_state = tbl_state;
      unique case (s1_req_r)
        REQ_STATIC: begin
          priority if (local_is_dyn) begin
            res_status = ST_DYN;
          end else if (tbl_state != SLOT_INACTIVE) begin
            res_status = ST_BUSY;
          end else begin
            tbl_wr.en    = 1'b1;
            tbl_wr.state = SLOT_DEPLOYING;
            res_local    = s1_local_r;
            res_state    = SLOT_DEPLOYING;
          end
        end
        REQ_RELEASE: begin
          priority if (tbl_state == SLOT_ACTIVE) begin
            res_status = ST_WRONG;
          end else if (local_is_dyn && (tbl_state == SLOT_INACTIVE)) begin
            res_status = ST_WRONG;
          end else begin
            fl_ctrl.push = local_is_dyn && !fl_stat.full;
            tbl_wr.en    = 1'b1;
            tbl_wr.state = SLOT_INACTIVE;
            res_local    = s1_local_r;
            res_state    = SLOT_INACTIVE;
          end
        end
        REQ_DEPLOYED: begin
          if (tbl_state != SLOT_DEPLOYING) begin
            res_status = ST_WRONG;
          end else begin
            tbl_wr.en    = 1'b1;
            tbl_wr.state = SLOT_ACTIVE;
            res_local    = s1_local_r;
            res_state    = SLOT_ACTIVE;
          end
        end
        REQ_TERM: begin
          if (tbl_state != SLOT_ACTIVE) begin
            res_status = ST_WRONG;
          end else begin
            tbl_wr.en    = 1'b1;
            tbl_wr.state = SLOT_TERMINATING;
            res_local    = s1_local_r;
            res_state    = SLOT_TERMINATING;
          end
        end
        default: begin
          res_local = s1_local_r;
        end
      endcase
    end
    if (!s1_valid_r) begin
      tbl_wr.en = 1'b0;
      fl_ctrl   = '0;
    end
  end

  // result register
  logic        out_strobe_r;
  logic [2:0]  out_status_r;
  logic [15:0] out_result_id_r;
  logic [1:0]  out_slot_state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r     <= res_status;
    out_result_id_r  <= (res_status == ST_OK) ? {node_id_r, res_local} : NULL_WORKER_ID;
    out_slot_state_r <= res_state;
  end

  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_result_id  = out_result_id_r;
  assign out_slot_state = out_slot_state_r;

  `ASSERT_NEXT(a_word_follows, s1_valid_r, out_strobe_r)
  `ASSERT_IMPL(a_pop_xor_push, fl_ctrl.pop, !fl_ctrl.push)
  `ASSERT_IMPL(a_pop_not_empty, fl_ctrl.pop, !fl_stat.empty)
  `ASSERT_IMPL(a_push_not_full, fl_ctrl.push, !fl_stat.full)
  `ASSERT_IMPL(a_write_from_item, tbl_wr.en, s1_valid_r)

endmodule

>>> tb/worker_id_table_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// worker_id_table_allocator_tb
// Drives slot requests into the allocator and checks every reply word
// against a behavioral model of the slot table and free-ID FIFO or the
// reply given in the directed table. The directed table of requests comes
// first, then random traffic in phases under different node_id settings.
// ----------------------------------------------------------------------------
module worker_id_table_allocator_tb;
  import wita_pkg::*;

  localparam int SLOT_N    = SLOT_COUNT_DEF;
  localparam int DYN_BASE  = DYNAMIC_BASE_DEF;
  localparam int DYN_COUNT = DYNAMIC_COUNT_DEF;

  localparam logic [2:0] CFG_NODE_ID_ADDR = 3'd0;
  // request codes with no meaning to the block
  localparam logic [2:0] REQ_UNDEF6 = 3'd6;
  localparam logic [2:0] REQ_UNDEF7 = 3'd7;

  typedef struct packed {
    status_t     status;
    logic [15:0] id;
    slot_state_t st;
  } reply_t;

  typedef struct packed {
    logic [2:0]  rq;
    logic [15:0] wid;
    logic        known;
    reply_t      want;
  } stim_row_t;

  localparam reply_t BY_MODEL = '{ST_OK, NULL_WORKER_ID, SLOT_INACTIVE};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_req_type = '0;
  logic [15:0] in_worker_id = '0;
  logic        out_strobe;
  logic [2:0]  out_status;
  logic [15:0] out_result_id;
  logic [1:0]  out_slot_state;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  worker_id_table_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_worker_id(in_worker_id),
    .out_strobe(out_strobe), .out_status(out_status),
    .out_result_id(out_result_id), .out_slot_state(out_slot_state),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // model of the slot table and free-ID FIFO
  slot_state_t slots [SLOT_N];
  logic [5:0]  free_ids [DYN_COUNT];
  int          take_ptr;
  int          ret_ptr;
  int          free_cnt;
  logic [7:0]  node_id;

  reply_t      due_replies [$];
  reply_t      head;
  int          fails = 0;
  int          no_gap_left = 0;

  function automatic reply_t granted(logic [7:0] loc, slot_state_t st);
    reply_t r;
    r.status = ST_OK;
    r.id = {node_id, loc};
    r.st = st;
    return r;
  endfunction

  function automatic reply_t next_reply(logic [2:0] rq, logic [15:0] wid);
    reply_t      r;
    logic [7:0]  loc;
    slot_state_t cur;
    logic [5:0]  fid;
    r = BY_MODEL;
    loc = wid[7:0];
    if (rq == REQ_DYNAMIC) begin
      if (free_cnt == 0) begin
        r.status = ST_NO_FREE;
      end else begin
        fid = free_ids[take_ptr];
        if (slots[fid] != SLOT_INACTIVE) begin
          r.status = ST_BUSY;
          r.st = slots[fid];
        end else begin
          take_ptr = (take_ptr + 1) % DYN_COUNT;
          free_cnt--;
          slots[fid] = SLOT_DEPLOYING;
          r = granted({2'b00, fid}, SLOT_DEPLOYING);
        end
      end
      return r;
    end
    if (rq > REQ_QUERY) begin
      r.status = ST_WRONG;
      return r;
    end
    if (loc >= SLOT_N) begin
      r.status = ST_RANGE;
      return r;
    end
    cur = slots[loc];
    r.st = cur;
    case (rq)
      REQ_STATIC: begin
        if (loc >= DYN_BASE) r.status = ST_DYN;
        else if (cur != SLOT_INACTIVE) r.status = ST_BUSY;
        else begin
          slots[loc] = SLOT_DEPLOYING;
          r = granted(loc, SLOT_DEPLOYING);
        end
      end
      REQ_RELEASE: begin
        // an inactive dynamic slot already has its ID in the FIFO
        if (cur == SLOT_ACTIVE || (loc >= DYN_BASE && cur == SLOT_INACTIVE)) begin
          r.status = ST_WRONG;
        end else begin
          if (loc >= DYN_BASE && free_cnt < DYN_COUNT) begin
            free_ids[ret_ptr] = loc[5:0];
            ret_ptr = (ret_ptr + 1) % DYN_COUNT;
            free_cnt++;
          end
          slots[loc] = SLOT_INACTIVE;
          r = granted(loc, SLOT_INACTIVE);
        end
      end
      REQ_DEPLOYED: begin
        if (cur != SLOT_DEPLOYING) r.status = ST_WRONG;
        else begin
          slots[loc] = SLOT_ACTIVE;
          r = granted(loc, SLOT_ACTIVE);
        end
      end
      REQ_TERM: begin
        if (cur != SLOT_ACTIVE) r.status = ST_WRONG;
        else begin
          slots[loc] = SLOT_TERMINATING;
          r = granted(loc, SLOT_TERMINATING);
        end
      end
      default: r = granted(loc, cur);
    endcase
    return r;
  endfunction

  // result words: one per request, cannot be held off
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (due_replies.size() == 0) begin
        $error("result word with none expected");
        fails++;
      end else begin
        head = due_replies.pop_front();
        if (out_status !== head.status) begin
          $error("status: expected %0d, actual %0d", head.status, out_status);
          fails++;
        end
        if (out_result_id !== head.id) begin
          $error("result_id: expected %h, actual %h", head.id, out_result_id);
          fails++;
        end
        if (out_slot_state !== head.st) begin
          $error("slot_state: expected %0d, actual %0d", head.st, out_slot_state);
          fails++;
        end
      end
    end
  end

  task automatic issue(input logic [2:0] rq, input logic [15:0] wid, input logic known,
                       input reply_t want);
    reply_t pred;
    int     gap;
    @(negedge clk);
    start <= 1'b1;
    in_req_type <= rq;
    in_worker_id <= wid;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = next_reply(rq, wid);
    due_replies.push_back(known ? want : pred);
    if (no_gap_left == 0 && $urandom_range(0, 39) == 0) no_gap_left = $urandom_range(10, 40);
    if (no_gap_left > 0) begin
      no_gap_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 10);
    end
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    wait (due_replies.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [7:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_NODE_ID_ADDR;
    pwdata <= {24'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    node_id = val;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // mostly legal lifecycle steps on a randomly chosen slot, the rest noise
  task automatic random_item(output logic [2:0] rq, output logic [15:0] wid);
    logic [7:0] loc;
    if ($urandom_range(0, 9) < 7) begin
      loc = 8'($urandom_range(0, SLOT_N - 1));
      case (slots[loc])
        SLOT_INACTIVE:  rq = (loc < DYN_BASE) ? REQ_STATIC : REQ_DYNAMIC;
        SLOT_DEPLOYING: rq = ($urandom_range(0, 2) == 0) ? REQ_RELEASE : REQ_DEPLOYED;
        SLOT_ACTIVE:    rq = ($urandom_range(0, 5) == 0) ? REQ_QUERY : REQ_TERM;
        default:        rq = REQ_RELEASE;
      endcase
      wid = {8'($urandom), loc};
    end else begin
      rq = 3'($urandom_range(0, 7));
      wid = 16'($urandom);
      if ($urandom_range(0, 2) != 0) wid[7:0] = 8'($urandom_range(0, SLOT_N - 1));
    end
  endtask

  stim_row_t dir_rows [0:21] = '{
    '{REQ_QUERY,    16'h0000, 1'b1, '{ST_OK, 16'hFF00, SLOT_INACTIVE}},
    '{REQ_QUERY,    16'hFFFF, 1'b1, '{ST_RANGE, 16'h0000, SLOT_INACTIVE}},
    '{REQ_STATIC,   16'hFF1F, 1'b1, '{ST_OK, 16'hFF1F, SLOT_DEPLOYING}},
    '{REQ_STATIC,   16'h001F, 1'b1, '{ST_BUSY, 16'h0000, SLOT_DEPLOYING}},
    '{REQ_STATIC,   16'h0020, 1'b1, '{ST_DYN, 16'h0000, SLOT_INACTIVE}},
    '{REQ_STATIC,   16'hA53F, 1'b1, '{ST_DYN, 16'h0000, SLOT_INACTIVE}},
    '{REQ_DYNAMIC,  16'hFFFF, 1'b1, '{ST_OK, 16'hFF20, SLOT_DEPLOYING}},
    '{REQ_RELEASE,  16'h0020, 1'b1, '{ST_OK, 16'hFF20, SLOT_INACTIVE}},
    '{REQ_RELEASE,  16'h0021, 1'b1, '{ST_WRONG, 16'h0000, SLOT_INACTIVE}},
    '{REQ_RELEASE,  16'h5A00, 1'b1, '{ST_OK, 16'hFF00, SLOT_INACTIVE}},
    '{REQ_DEPLOYED, 16'h001F, 1'b0, BY_MODEL},
    '{REQ_RELEASE,  16'h001F, 1'b1, '{ST_WRONG, 16'h0000, SLOT_ACTIVE}},
    '{REQ_TERM,     16'h001F, 1'b0, BY_MODEL},
    '{REQ_DEPLOYED, 16'h001F, 1'b1, '{ST_WRONG, 16'h0000, SLOT_TERMINATING}},
    '{REQ_TERM,     16'h0005, 1'b1, '{ST_WRONG, 16'h0000, SLOT_INACTIVE}},
    '{REQ_RELEASE,  16'h001F, 1'b0, BY_MODEL},
    '{REQ_UNDEF6,   16'h0000, 1'b1, '{ST_WRONG, 16'h0000, SLOT_INACTIVE}},
    '{REQ_UNDEF7,   16'hFFFF, 1'b1, '{ST_WRONG, 16'h0000, SLOT_INACTIVE}},
    '{REQ_DEPLOYED, 16'h0040, 1'b1, '{ST_RANGE, 16'h0000, SLOT_INACTIVE}},
    '{REQ_RELEASE,  16'h0080, 1'b1, '{ST_RANGE, 16'h0000, SLOT_INACTIVE}},
    '{REQ_DYNAMIC,  16'h0000, 1'b0, BY_MODEL},
    '{REQ_QUERY,    16'h0021, 1'b0, BY_MODEL}
  };

  initial begin
    logic [7:0]  node_vals [4];
    logic [2:0]  rq;
    logic [15:0] wid;
    for (int i = 0; i < SLOT_N; i++) slots[i] = SLOT_INACTIVE;
    for (int i = 0; i < DYN_COUNT; i++) free_ids[i] = 6'(DYN_BASE + i);
    take_ptr = 0;
    ret_ptr = 0;
    free_cnt = DYN_COUNT;
    node_id = 8'h00;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    cfg_write(8'hFF);
    foreach (dir_rows[i]) issue(dir_rows[i].rq, dir_rows[i].wid, dir_rows[i].known,
                                dir_rows[i].want);
    settle();

    node_vals = '{8'h00, 8'($urandom), 8'h80, 8'($urandom)};
    foreach (node_vals[p]) begin
      cfg_write(node_vals[p]);
      for (int n = 0; n < 360; n++) begin
        // empty the free-ID FIFO and run past it once per phase
        if (n == 180) begin
          for (int k = 0; k < DYN_COUNT + 4; k++) issue(REQ_DYNAMIC, 16'($urandom), 1'b0,
                                                         BY_MODEL);
        end
        if ($urandom_range(0, 149) == 0) settle();
        random_item(rq, wid);
        issue(rq, wid, 1'b0, BY_MODEL);
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/wita_pkg.sv
rtl/wita_slot_table.sv
rtl/wita_free_list.sv
rtl/worker_id_table_allocator.sv
tb/worker_id_table_allocator_tb.sv
